>>> design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the frame deframer.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/wsd_pkg.sv
// ============================================================================
// WebSocket deframer package
// Types, codes and the opcode decoder shared by the deframer modules.
// ============================================================================
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [2:0] KIND_CONT    = 3'd0;
    localparam logic [2:0] KIND_TEXT    = 3'd1;
    localparam logic [2:0] KIND_BINARY  = 3'd2;
    localparam logic [2:0] KIND_CLOSE   = 3'd3;
    localparam logic [2:0] KIND_PING    = 3'd4;
    localparam logic [2:0] KIND_PONG    = 3'd5;
    localparam logic [2:0] KIND_INVALID = 3'd6;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Byte counts of the extended length and mask key fields. An 8-byte
    // length is loaded as zero: the 3-bit down counter wraps to seven.
    localparam logic [2:0] CNT_EXT16 = 3'd2;
    localparam logic [2:0] CNT_EXT64 = 3'd0;
    localparam logic [2:0] CNT_MASK  = 3'd4;

    // One registered stream byte handed from the input stage to the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

    function automatic logic [2:0] map_opcode(input logic [3:0] op);
        logic [2:0] k;
        unique case (op)
            OP_CONT:   k = KIND_CONT;
            OP_TEXT:   k = KIND_TEXT;
            OP_BINARY: k = KIND_BINARY;
            OP_CLOSE:  k = KIND_CLOSE;
            OP_PING:   k = KIND_PING;
            OP_PONG:   k = KIND_PONG;
            default:   k = KIND_INVALID;
        endcase
        return k;
    endfunction

endpackage

>>> design/wsd_byte_if.sv
// ============================================================================
// Byte stream interface
// Valid/ready channel carrying one raw stream byte per transaction.
// ============================================================================
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

>>> design/wsd_result_if.sv
// ============================================================================
// Result interface
// Valid/ready channel carrying one unmasked payload result per transaction.
// ============================================================================
interface wsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_data;
    logic [2:0] frame_kind;
    logic       fin_flag;
    logic       frame_end;
    logic       message_end;

    modport source (
        output valid, output payload_byte, output has_data, output frame_kind,
        output fin_flag, output frame_end, output message_end, input ready
    );
    modport sink (
        input valid, input payload_byte, input has_data, input frame_kind,
        input fin_flag, input frame_end, input message_end, output ready
    );
endinterface

>>> design/wsd_in_stage.sv
// ============================================================================
// Deframer input stage
// Registers each accepted stream byte until the parser consumes it.
// ============================================================================
module wsd_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    wsd_byte_if.sink            stream,
    input  logic                take,
    output wsd_pkg::byte_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    // Room whenever the stage is empty or its byte leaves this cycle.
    assign stream.ready = !valid_reg || take;
    assign accept       = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= stream.in_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

>>> design/wsd_parser.sv
// ============================================================================
// Deframer parser
// Header state machine, length and mask tracking, and the result register.
// ============================================================================
`include "assert_macros.svh"

module wsd_parser
#(
    parameter int LEN_BITS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  wsd_pkg::byte_item_t item,
    output logic                take,
    wsd_result_if.source        result
);

    wsd_pkg::phase_t     phase_reg;
    wsd_pkg::phase_t     phase_next;
    logic                fin_reg;
    logic                fin_next;
    logic [2:0]          kind_reg;
    logic [2:0]          kind_next;
    logic                masked_reg;
    logic                masked_next;
    logic [LEN_BITS-1:0] rem_reg;
    logic [LEN_BITS-1:0] rem_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [2:0]          cnt_reg;
    logic [2:0]          cnt_next;
    logic [31:0]         key_reg;
    logic [31:0]         key_next;
    logic [1:0]          mph_reg;
    logic [1:0]          mph_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_data_reg;
    logic                out_has_reg;
    logic [2:0]          out_kind_reg;
    logic                out_fin_reg;
    logic                out_end_reg;

    logic [7:0]          b;
    logic [6:0]          len7;
    logic                len7_ext;
    logic [LEN_BITS-1:0] len7_wide;
    logic [LEN_BITS-1:0] ext_shift;
    logic                ext_ovf;
    logic [LEN_BITS-1:0] ext_final;
    logic [2:0]          cnt_dec;
    logic [LEN_BITS-1:0] rem_dec;
    logic [7:0]          key_byte;

    logic                emit;
    logic [7:0]          emit_data;
    logic                emit_has;

    assign take = item.valid && (!out_valid_reg || result.ready);

    // Shared datapath terms.
    assign b         = item.data;
    assign len7      = b[6:0];
    assign len7_ext  = (len7 == wsd_pkg::LEN7_EXT16) || (len7 == wsd_pkg::LEN7_EXT64);
    assign len7_wide = {{(LEN_BITS-7){1'b0}}, len7};
    assign ext_shift = {rem_reg[LEN_BITS-9:0], b};
    assign ext_ovf   = ovf_reg || (rem_reg[LEN_BITS-1 -: 8] != 8'd0);
    assign ext_final = ext_ovf ? {LEN_BITS{1'b1}} : ext_shift;
    assign cnt_dec   = cnt_reg - 3'd1;
    assign rem_dec   = (rem_reg != '0) ? (rem_reg - {{(LEN_BITS-1){1'b0}}, 1'b1}) : rem_reg;

    always_comb
    begin
        case (mph_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        logic                do_after;
        logic                after_masked;
        logic [LEN_BITS-1:0] after_len;

        phase_next   = phase_reg;
        fin_next     = fin_reg;
        kind_next    = kind_reg;
        masked_next  = masked_reg;
        rem_next     = rem_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        key_next     = key_reg;
        mph_next     = mph_reg;
        do_after     = 1'b0;
        after_masked = masked_reg;
        after_len    = rem_reg;

        if (take)
        begin
            unique case (phase_reg)
                wsd_pkg::PH_HDR2:
                begin
                    masked_next = b[7];
                    mph_next    = 2'd0;
                    if (len7_ext)
                    begin
                        cnt_next   = (len7 == wsd_pkg::LEN7_EXT16) ? wsd_pkg::CNT_EXT16
                                                                   : wsd_pkg::CNT_EXT64;
                        rem_next   = '0;
                        ovf_next   = 1'b0;
                        phase_next = wsd_pkg::PH_EXTLEN;
                    end
                    else
                    begin
                        rem_next     = len7_wide;
                        do_after     = 1'b1;
                        after_masked = b[7];
                        after_len    = len7_wide;
                    end
                end
                wsd_pkg::PH_EXTLEN:
                begin
                    cnt_next = cnt_dec;
                    ovf_next = ext_ovf;
                    rem_next = ext_shift;
                    if (cnt_dec == 3'd0)
                    begin
                        rem_next  = ext_final;
                        do_after  = 1'b1;
                        after_len = ext_final;
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    key_next = {key_reg[23:0], b};
                    cnt_next = cnt_dec;
                    if (cnt_dec == 3'd0)
                    begin
                        phase_next = (rem_reg == '0) ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_PAYLOAD;
                    end
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    mph_next = mph_reg + 2'd1;
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = wsd_pkg::PH_HDR1;
                    end
                end
                default:
                begin
                    // First header byte; unused phase codes land here as well.
                    fin_next   = b[7];
                    kind_next  = wsd_pkg::map_opcode(b[3:0]);
                    phase_next = wsd_pkg::PH_HDR2;
                end
            endcase

            if (do_after)
            begin
                if (after_masked)
                begin
                    phase_next = wsd_pkg::PH_MASK;
                    cnt_next   = wsd_pkg::CNT_MASK;
                    key_next   = '0;
                end
                else if (after_len == '0)
                begin
                    phase_next = wsd_pkg::PH_HDR1;
                end
                else
                begin
                    phase_next = wsd_pkg::PH_PAYLOAD;
                end
            end
        end
    end

    // Result generation.
    always_comb
    begin
        emit      = 1'b0;
        emit_data = 8'd0;
        emit_has  = 1'b0;
        unique case (phase_reg)
            wsd_pkg::PH_HDR2:
            begin
                emit = !b[7] && !len7_ext && (len7 == 7'd0);
            end
            wsd_pkg::PH_EXTLEN:
            begin
                emit = (cnt_dec == 3'd0) && !masked_reg && (ext_final == '0);
            end
            wsd_pkg::PH_MASK:
            begin
                emit = (cnt_dec == 3'd0) && (rem_reg == '0);
            end
            wsd_pkg::PH_PAYLOAD:
            begin
                emit      = 1'b1;
                emit_has  = 1'b1;
                emit_data = masked_reg ? (b ^ key_byte) : b;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wsd_pkg::PH_HDR1;
            fin_reg       <= 1'b0;
            kind_reg      <= wsd_pkg::KIND_CONT;
            masked_reg    <= 1'b0;
            rem_reg       <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= 3'd0;
            key_reg       <= '0;
            mph_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            kind_reg      <= kind_next;
            masked_reg    <= masked_next;
            rem_reg       <= rem_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            key_reg       <= key_next;
            mph_reg       <= mph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The end flag of a payload byte is the decremented count hitting zero;
    // every other result closes an empty frame.
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_data_reg <= emit_data;
            out_has_reg  <= emit_has;
            out_kind_reg <= kind_reg;
            out_fin_reg  <= fin_reg;
            out_end_reg  <= emit_has ? (rem_dec == '0) : 1'b1;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.payload_byte = out_data_reg;
    assign result.has_data     = out_has_reg;
    assign result.frame_kind   = out_kind_reg;
    assign result.fin_flag     = out_fin_reg;
    assign result.frame_end    = out_end_reg;
    assign result.message_end  = out_end_reg && out_fin_reg;

    `ASSERT_IMPLIES(a_payload_len_live, clk, rst_n,
                    phase_reg == wsd_pkg::PH_PAYLOAD, rem_reg != '0)
    `ASSERT_IMPLIES(a_empty_result_ends, clk, rst_n,
                    result.valid && !result.has_data, result.frame_end && result.payload_byte == 8'd0)
    `ASSERT_NEXT(a_end_back_to_hdr, clk, rst_n,
                 take && emit && (!emit_has || rem_dec == '0), phase_reg == wsd_pkg::PH_HDR1)

endmodule

>>> design/websocket_frame_deframer.sv
// Flow: an accepted byte is registered in the input stage; the parser then registers its result.
// Throughput: one byte per cycle unless results back up; the parse logic holds no loop over cycles.
// The input register decouples the sides: one more byte is accepted while a finished result waits.
// Reset (rst_n, asynchronous, active low) empties both stages and returns to the header phase.
// ============================================================================
// WebSocket frame deframer
// Parses a framed byte stream and delivers unmasked payload bytes with tags.
// ============================================================================
//
// Structure: an input stage registers each accepted byte; the parser then
// advances the header state machine on that byte and, when the byte yields a
// result, loads the result register in the same cycle. The header bytes, the
// extended length bytes and the mask key bytes yield no result, except as
// below. Each payload byte yields one result, in a masked frame XORed with
// the mask key byte selected by its position modulo four. A frame with an
// empty payload yields one dataless result on the byte completing its header.
//
// An extended length that does not fit in LEN_BITS saturates to all ones.
// Stalls on the result side propagate to the input side one transaction
// deep: the input stage keeps accepting until both registers hold data.
module websocket_frame_deframer
#(
    parameter int LEN_BITS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    wsd_byte_if.sink     stream,
    wsd_result_if.source result
);

    wsd_pkg::byte_item_t item;
    logic                take;

    // Input register: holds one transaction until the parser consumes it.
    wsd_in_stage u_in_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .take   (take),
        .item   (item)
    );

    // Header parsing, length countdown, unmasking and the result register.
    wsd_parser
    #(
        .LEN_BITS (LEN_BITS)
    )
    u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .take   (take),
        .result (result)
    );

endmodule
